// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the lottery process scheduler
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int NumSlots   = 64;
  localparam int SlotBits   = 6;
  localparam int TicketBits = 16;
  localparam logic [TicketBits-1:0] TicketMax = '1;

  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_READ   = 3'd1,
    MODE_RESUME = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_YIELD  = 3'd4
  } mode_e;

  localparam logic [2:0] ST_DEAD    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;

  localparam logic [0:0] REG_QUANTUM = 1'b0;
  localparam logic [0:0] REG_FLOOR   = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  slot;
    logic [2:0]  proc_state;
    logic [15:0] tickets;
    logic [7:0]  quantum_left;
    logic [31:0] alarm_time;
    logic [31:0] now_ticks;
    logic [14:0] random_draw;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  running_slot;
    logic [5:0]  previous_slot;
    logic        switched;
    logic [63:0] alarm_mask;
    logic        stopped_report;
    logic [2:0]  read_state;
    logic [15:0] read_tickets;
    logic [7:0]  read_quantum_left;
    logic [31:0] read_alarm;
  } out_word_t;

  // one slot entry as held in memory
  typedef struct packed {
    logic [2:0]            st;
    logic [TicketBits-1:0] tk;
    logic [7:0]            q;
    logic [31:0]           al;
  } entry_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

// ===== rtl/lps_div.sv =====
// ----------------------------------------------------------------------------
// lps_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lps_div
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[31]};
    if (req.start) begin
      q_nxt = req.num; r_nxt = '0; d_nxt = req.den; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = 32'(trial - {1'b0, d_r});
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = 6'(cnt_r + 6'd1);
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== rtl/lottery_process_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// lottery_process_scheduler_core
// lottery scheduler over a 64-slot process table held in one memory
// ----------------------------------------------------------------------------
// write, read, unknown modes and resume of a slot not stopped: read the slot, then answer
// resume of a stopped slot: mark it ready, inflating its tickets by a divide if needed
// stop and yield: two passes over the table and a draw divide (no divide with no
//   ready tickets); one more divide when the running slot is inflated
// one word at a time, next start taken in the strobe cycle; receiver cannot stall
// reset: a clearing pass marks every slot dead; quantum 50, floor 40
module lottery_process_scheduler_core
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_RD     = 14'b00000000000100,
    S_DO     = 14'b00000000001000,
    S_RSDIV  = 14'b00000000010000,
    S_RSMUL  = 14'b00000000100000,
    S_SCAN   = 14'b00000001000000,
    S_MOD    = 14'b00000010000000,
    S_PICK   = 14'b00000100000000,
    S_WRD    = 14'b00001000000000,
    S_WIN    = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_RSRD   = 14'b01000000000000,
    S_MODW   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]  qlen_r;
  logic [15:0] floor_r;
  logic        cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FLOOR) prdata = {16'd0, floor_r};
    else                       prdata = {24'd0, qlen_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= 8'd50; floor_r <= 16'd40;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_QUANTUM) qlen_r <= pwdata[7:0];
      else                         floor_r <= pwdata[15:0];
    end
  end

  // slot memory, one read and one write port
  entry_t mem [NumSlots];
  logic [SlotBits-1:0] ra, wa;
  logic   we;
  entry_t wd, rd_r;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // divider shared by rescheduling and the draw
  div_req_t dreq;
  logic        ddone;
  logic [31:0] dq, drem;
  lps_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quot(dq), .rem(drem));

  in_word_t  iw_r;
  out_word_t ow_r, ow_nxt;
  logic [SlotBits-1:0] cur_r, cur_nxt, last_r, last_nxt;
  logic [SlotBits-1:0] tgt_r, tgt_nxt, next_r, next_nxt;
  logic [6:0]  idx_r, idx_nxt;          // scan counter, also the clearing pass
  logic [21:0] total_r, total_nxt, acc_r, acc_nxt;
  logic [14:0] pick_r, pick_nxt;
  logic        found_r, found_nxt, resched_r, resched_nxt, ov_r, ov_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [SlotBits-1:0] sidx_r;          // slot whose read is in rd_r
  logic [63:0] mask_r, mask_nxt;
  entry_t e;
  logic [15:0] tdec;
  logic [21:0] acc_sum;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ow_nxt = ow_r; cur_nxt = cur_r; last_nxt = last_r; tgt_nxt = tgt_r;
    next_nxt = next_r; idx_nxt = idx_r; total_nxt = total_r; acc_nxt = acc_r;
    pick_nxt = pick_r; found_nxt = found_r; resched_nxt = resched_r;
    prod_nxt = prod_r; mask_nxt = mask_r; ov_nxt = 1'b0;
    ra = tgt_r; wa = tgt_r; we = 1'b0; wd = rd_r;
    dreq = '0; e = rd_r; tdec = '0; acc_sum = '0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; wa = idx_r[SlotBits-1:0]; wd = '0;
        idx_nxt = 7'(idx_r + 7'd1);
        if (idx_r == 7'(NumSlots - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          tgt_nxt = in_word.slot;
          ra = in_word.slot;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_DO;           // memory read in flight
      S_DO: begin
        ow_nxt = '0;
        unique case (iw_r.mode)
          MODE_WRITE: begin
            we = 1'b1;
            wd = '{st: iw_r.proc_state, tk: iw_r.tickets, q: iw_r.quantum_left,
                   al: iw_r.alarm_time};
            state_nxt = S_OUT;
          end
          MODE_READ: begin
            ow_nxt.read_state = rd_r.st; ow_nxt.read_tickets = rd_r.tk;
            ow_nxt.read_quantum_left = rd_r.q; ow_nxt.read_alarm = rd_r.al;
            state_nxt = S_OUT;
          end
          MODE_RESUME: begin
            resched_nxt = 1'b0;
            if (rd_r.st == ST_STOPPED) state_nxt = S_RSRD;
            else                       state_nxt = S_OUT;
          end
          MODE_STOP, MODE_YIELD: begin
            // current slot is read; reschedule if running
            tgt_nxt = cur_r;
            resched_nxt = 1'b1;
            if (iw_r.mode == MODE_STOP) ow_nxt.stopped_report = 1'b1;
            state_nxt = S_RSRD;
            ra = cur_r;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_RSRD: begin
        // rd_r holds the target entry (re-read after tgt change)
        ra = tgt_r;
        if (resched_r && iw_r.mode == MODE_STOP && !found_r) begin
          we = 1'b1; wd = rd_r; wd.st = ST_STOPPED;
          found_nxt = 1'b1;                // wait and re-read
        end else if (found_r || !resched_r) begin
          found_nxt = 1'b0;
          state_nxt = S_RSDIV;
        end else begin
          found_nxt = 1'b1;                // wait for the re-read
        end
      end
      S_RSDIV: begin
        found_nxt = 1'b0;
        if (!resched_r || rd_r.st == ST_RUNNING || rd_r.st == ST_STOPPED &&
            iw_r.mode == MODE_RESUME) begin
          if (rd_r.q != 8'd0 && rd_r.q < qlen_r) begin
            dreq.start = 1'b1; dreq.num = {24'd0, qlen_r};
            dreq.den = {24'd0, 8'(qlen_r - rd_r.q)};
            state_nxt = S_RSMUL;
          end else begin
            we = 1'b1; wd.st = ST_READY;
            state_nxt = resched_r ? S_SCAN : S_OUT;
          end
        end else begin
          state_nxt = S_SCAN;
        end
        if (state_nxt == S_SCAN) begin
          last_nxt = cur_r; idx_nxt = 7'd1; total_nxt = '0; mask_nxt = '0;
          ra = SlotBits'(1);
        end
      end
      S_RSMUL: begin
        // rd_r keeps the target entry while the divide runs
        if (ddone) begin
          prod_nxt = 32'(rd_r.tk) * {24'd0, dq[7:0]};
          ov_nxt = 1'b1;
        end
        if (ov_r) begin
          we = 1'b1; wd.st = ST_READY;
          wd.tk = (prod_r > 32'(TicketMax)) ? TicketMax : prod_r[TicketBits-1:0];
          if (resched_r) begin
            state_nxt = S_SCAN;
            last_nxt = cur_r; idx_nxt = 7'd1; total_nxt = '0; mask_nxt = '0;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // pass one: rd_r holds slot sidx_r, issue read of idx_r
        // the first cycle only issues the read of slot 1
        ra = idx_r[SlotBits-1:0];
        if (idx_r != 7'd1) begin
          if (e.st != ST_DEAD) begin
            if (e.al != '0 && e.al < iw_r.now_ticks) begin
              we = 1'b1; wa = sidx_r; wd = e; wd.al = '0;
              mask_nxt[sidx_r] = 1'b1;
            end
            if (e.st == ST_READY) total_nxt = 22'(total_r + 22'(e.tk));
          end
        end
        if (idx_r == 7'(NumSlots)) begin
          state_nxt = S_MOD;
        end else begin
          idx_nxt = 7'(idx_r + 7'd1);
        end
      end
      S_MOD: begin
        next_nxt = '0; found_nxt = 1'b0;
        if (total_r == '0) begin
          state_nxt = S_WRD; tgt_nxt = '0; ra = '0;
        end else begin
          dreq.start = 1'b1; dreq.num = {17'd0, iw_r.random_draw};
          dreq.den = {10'd0, total_r};
          state_nxt = S_MODW;
        end
      end
      S_MODW: begin
        ra = SlotBits'(1);
        if (ddone) begin
          pick_nxt = drem[14:0]; acc_nxt = '0; idx_nxt = 7'd1;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        ra = idx_r[SlotBits-1:0];
        if (idx_r != 7'd1 && !found_r && e.st == ST_READY) begin
          acc_sum = 22'(acc_r + 22'(e.tk));
          acc_nxt = acc_sum;
          if (acc_sum > 22'(pick_r)) begin
            found_nxt = 1'b1; next_nxt = sidx_r;
          end
        end
        if (idx_r == 7'(NumSlots)) begin
          state_nxt = S_WRD;
        end else begin
          idx_nxt = 7'(idx_r + 7'd1);
        end
        if (state_nxt == S_WRD) begin
          tgt_nxt = found_nxt ? next_nxt : '0; ra = tgt_nxt;
        end
      end
      S_WRD: begin
        ra = tgt_r; found_nxt = 1'b0; state_nxt = S_WIN;
      end
      S_WIN: begin
        tdec = (rd_r.tk > floor_r) ? 16'(rd_r.tk - 16'd1) : floor_r;
        we = 1'b1; wd.tk = tdec; wd.st = ST_RUNNING; wd.q = qlen_r;
        ow_nxt.switched = (tgt_r != cur_r);
        ow_nxt.alarm_mask = mask_r;
        cur_nxt = tgt_r;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_OUT) begin
      ow_nxt.running_slot = cur_r; ow_nxt.previous_slot = last_r;
    end
  end

  // scan passes start one read behind: sidx_r tracks the slot of rd_r
  always_ff @(posedge clk) begin
    sidx_r <= ra;
    if (state_r == S_IDLE && start) iw_r <= in_word;
    ow_r <= ow_nxt; tgt_r <= tgt_nxt; next_r <= next_nxt;
    total_r <= total_nxt; acc_r <= acc_nxt; pick_r <= pick_nxt;
    prod_r <= prod_nxt; mask_r <= mask_nxt;
    if (!rst_n) begin
      state_r <= S_CLEAR; idx_r <= '0; cur_r <= '0; last_r <= '0;
      found_r <= 1'b0; resched_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; cur_r <= cur_nxt; last_r <= last_nxt;
      found_r <= found_nxt; resched_r <= resched_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= (state_r == S_OUT);
  end
  assign out_word = ow_r;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lottery process scheduler core: slot table
// writes, reads, resume, stop and yield words, with the expected result of
// each word worked out by a behavioural copy of the scheduler and compared
// field by field with the result strobe
// ----------------------------------------------------------------------------
module testbench
  import lps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 6000;

  // ---------------------------------------------------------------------------
  // expected-result tracker, holds its own copy of the process table
  // ---------------------------------------------------------------------------
  class sched_scoreboard;
    logic [2:0]  slot_st [NumSlots];
    logic [15:0] slot_tk [NumSlots];
    logic [7:0]  slot_q  [NumSlots];
    logic [31:0] slot_al [NumSlots];
    logic [5:0]  cur_slot;
    logic [5:0]  prev_slot;
    logic [7:0]  quantum_len;
    logic [15:0] ticket_floor;
    out_word_t   pending_results[$];
    int          mismatches;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        slot_st[i] = ST_DEAD;
        slot_tk[i] = '0;
        slot_q[i]  = '0;
        slot_al[i] = '0;
      end
      cur_slot     = '0;
      prev_slot    = '0;
      quantum_len  = 8'd50;
      ticket_floor = 16'd40;
      mismatches   = 0;
    endfunction

    // partly used quantum inflates the tickets, then the slot is ready
    function void requeue(int s);
      logic [63:0] prod;
      int unsigned factor;
      if (slot_q[s] > 0 && slot_q[s] < quantum_len) begin
        factor = quantum_len / (quantum_len - slot_q[s]);
        prod   = 64'(slot_tk[s]) * factor;
        slot_tk[s] = (prod > 64'(TicketMax)) ? TicketMax : prod[15:0];
      end
      slot_st[s] = ST_READY;
    endfunction

    function void run_lottery(logic [31:0] now, logic [14:0] draw, ref out_word_t e);
      logic [31:0] total;
      logic [31:0] pick;
      logic [31:0] acc;
      logic [31:0] t;
      int          winner;
      if (slot_st[cur_slot] == ST_RUNNING) requeue(cur_slot);
      prev_slot = cur_slot;
      total = '0;
      for (int s = 1; s < NumSlots; s++) begin
        if (slot_st[s] == ST_DEAD) continue;
        if (slot_al[s] != 0 && slot_al[s] < now) begin
          slot_al[s] = '0;
          e.alarm_mask[s] = 1'b1;
        end
        if (slot_st[s] == ST_READY) total += slot_tk[s];
      end
      winner = 0;
      if (total > 0) begin
        pick = 32'(draw) % total;
        acc  = '0;
        for (int s = 1; s < NumSlots; s++) begin
          if (slot_st[s] != ST_READY) continue;
          acc += slot_tk[s];
          if (acc > pick) begin
            winner = s;
            break;
          end
        end
      end
      t = slot_tk[winner];
      t = (t > ticket_floor) ? t - 1 : 32'(ticket_floor);
      slot_tk[winner] = (t > TicketMax) ? TicketMax : t[15:0];
      slot_st[winner] = ST_RUNNING;
      slot_q[winner]  = quantum_len;
      e.switched      = (winner != cur_slot);
      cur_slot        = winner[5:0];
    endfunction

    function void note_word(in_word_t w);
      out_word_t e;
      e = '0;
      case (w.mode)
        MODE_WRITE: begin
          slot_st[w.slot] = w.proc_state;
          slot_tk[w.slot] = w.tickets;
          slot_q[w.slot]  = w.quantum_left;
          slot_al[w.slot] = w.alarm_time;
        end
        MODE_READ: begin
          e.read_state        = slot_st[w.slot];
          e.read_tickets      = slot_tk[w.slot];
          e.read_quantum_left = slot_q[w.slot];
          e.read_alarm        = slot_al[w.slot];
        end
        MODE_RESUME: if (slot_st[w.slot] == ST_STOPPED) requeue(w.slot);
        MODE_STOP, MODE_YIELD: begin
          if (w.mode == MODE_STOP) begin
            slot_st[cur_slot] = ST_STOPPED;
            e.stopped_report  = 1'b1;
          end
          run_lottery(w.now_ticks, w.random_draw, e);
        end
        default: ;
      endcase
      e.running_slot  = cur_slot;
      e.previous_slot = prev_slot;
      pending_results.push_back(e);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      end
    endfunction

    function void check_word(out_word_t a);
      out_word_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", a);
        return;
      end
      e = pending_results.pop_front();
      compare("running_slot", e.running_slot, a.running_slot);
      compare("previous_slot", e.previous_slot, a.previous_slot);
      compare("switched", e.switched, a.switched);
      compare("alarm_mask", e.alarm_mask, a.alarm_mask);
      compare("stopped_report", e.stopped_report, a.stopped_report);
      compare("read_state", e.read_state, a.read_state);
      compare("read_tickets", e.read_tickets, a.read_tickets);
      compare("read_quantum_left", e.read_quantum_left, a.read_quantum_left);
      compare("read_alarm", e.read_alarm, a.read_alarm);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb;
  int              idle_cycles;

  lottery_process_scheduler_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // results last one cycle and cannot be held off, so every strobe is taken
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_word);
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // send one word after a gap; start stays high straight into the next word
  // when the gap is zero, so it never drops and rises in one step
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    // busy read right after the edge is its value before that edge
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    // every word gives a result, a few spare cycles are plenty
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk) penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'd4 * REG_QUANTUM) sb.quantum_len = value[7:0];
    else sb.ticket_floor = value[15:0];
  endtask

  function automatic in_word_t make_word(logic [2:0] mode, logic [5:0] slot);
    in_word_t w;
    w = '0;
    w.mode = mode;
    w.slot = slot;
    return w;
  endfunction

  // random word, biased towards a small set of slots with live processes
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w = '0;
    w.random_draw = 15'($urandom_range(0, 32767));
    w.slot = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, 11));
    w.proc_state = ($urandom_range(0, 1) == 0) ? ST_READY : 3'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: w.tickets = 16'($urandom_range(0, 65535));
      1: w.tickets = 16'(32'hFFFF - $urandom_range(0, 3));
      default: w.tickets = 16'($urandom_range(0, 200));
    endcase
    w.quantum_left = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      w.alarm_time = $urandom();
      w.now_ticks  = $urandom();
    end else begin
      w.alarm_time = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 1000);
      w.now_ticks  = $urandom_range(0, 1200);
    end
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.mode = MODE_WRITE;
    else if (pick < 45) w.mode = MODE_READ;
    else if (pick < 55) w.mode = MODE_RESUME;
    else if (pick < 65) w.mode = MODE_STOP;
    else if (pick < 96) w.mode = MODE_YIELD;
    else                w.mode = 3'($urandom_range(5, 7));
    return w;
  endfunction

  task automatic run_random(int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      // a stretch with no gaps in each batch
      if (i >= count / 4 && i < count / 4 + 30) gap = 0;
      // hold off until the scheduler has answered everything
      if (i == count / 2) drain();
      send_word(random_word(), gap);
    end
  endtask

  task automatic run_directed();
    in_word_t w;
    w = make_word(MODE_WRITE, 6'd1);
    w.proc_state = ST_READY; w.tickets = 16'd100; w.quantum_left = 8'd10; w.alarm_time = 32'd5;
    send_word(w, 0);
    w = make_word(MODE_WRITE, 6'd2);
    w.proc_state = ST_READY; w.tickets = 16'hFFFF; w.alarm_time = 32'hFFFF_FFFF;
    send_word(w, 1);
    w = make_word(MODE_WRITE, 6'd63);
    w.proc_state = ST_STOPPED; w.tickets = 16'd3; w.quantum_left = 8'hFF;
    send_word(w, 0);
    w = make_word(MODE_WRITE, 6'd5);
    w.proc_state = 3'd7; w.tickets = 16'd0; w.alarm_time = 32'd1;
    send_word(w, 2);
    send_word(make_word(MODE_READ, 6'd63), 0);
    send_word(make_word(MODE_READ, 6'd0), 0);
    w = make_word(MODE_YIELD, 6'd0);
    w.now_ticks = 32'hFFFF_FFFF; w.random_draw = 15'd0;
    send_word(w, 0);
    w.random_draw = 15'h7FFF;
    send_word(w, 3);
    send_word(make_word(MODE_RESUME, 6'd63), 0);
    send_word(make_word(MODE_RESUME, 6'd1), 0);
    w = make_word(MODE_STOP, 6'd0);
    w.random_draw = 15'd12345;
    send_word(w, 0);
    for (int k = 5; k < 8; k++) send_word(make_word(k[2:0], 6'h3F), 0);
    // kill slots 1 to 3 and 63 so the idle slot can win
    for (int s = 1; s < 4; s++) send_word(make_word(MODE_WRITE, s[5:0]), 0);
    send_word(make_word(MODE_WRITE, 6'd63), 0);
    send_word(make_word(MODE_YIELD, 6'd0), 0);
    // stop the idle slot itself
    send_word(make_word(MODE_STOP, 6'd0), 0);
    send_word(make_word(MODE_READ, 6'd0), 0);
    send_word(make_word(MODE_READ, 6'd1), 0);
  endtask

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_word  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings, then the clearing pass ends when busy first drops
    run_directed();
    run_random(350);
    drain();

    write_reg(3'd4 * REG_QUANTUM, 32'd1);
    write_reg(3'd4 * REG_FLOOR, 32'd0);
    run_directed();
    run_random(330);
    drain();

    write_reg(3'd4 * REG_QUANTUM, 32'd255);
    write_reg(3'd4 * REG_FLOOR, 32'hFFFF);
    run_random(330);
    drain();

    write_reg(3'd4 * REG_QUANTUM, 32'($urandom_range(2, 254)));
    write_reg(3'd4 * REG_FLOOR, 32'($urandom_range(0, 300)));
    run_random(350);
    drain();

    write_reg(3'd4 * REG_QUANTUM, 32'd200);
    write_reg(3'd4 * REG_FLOOR, 32'd1);
    run_random(350);
    drain();

    // leftover expectations count as failures
    repeat (300) @(negedge clk);
    if (sb.pending_results.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
